// File: src/pgmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgmr_pkg
// Shared types and constants of the parity group multicast router.
// ----------------------------------------------------------------------------
package pgmr_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned BS_W   = 16;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = BS_W'(1);

  localparam logic RESULT_REPORT  = 1'b0;
  localparam logic RESULT_FORWARD = 1'b1;

  // One member table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [SEQ_W-1:0]  last_seq;
  } pgmr_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_UPDATE,
    ST_DECIDE,
    ST_FAN,
    ST_FLUSH
  } pgmr_state_t;

endpackage : pgmr_pkg
`default_nettype wire

// File: src/pgmr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgmr_mem
// Member table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgmr_mem
  import pgmr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pgmr_entry_t   wdata,
  input  wire logic [AW-1:0] raddr,
  output pgmr_entry_t        rdata
);

  pgmr_entry_t mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule : pgmr_mem
`default_nettype wire

// File: src/pgmr_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgmr_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pgmr_mod
  import pgmr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SEQ_W-1:0] dividend,
  input  wire logic [BS_W-1:0]  divisor,
  output logic                  done,
  output logic                  rem_nz
);

  localparam int unsigned CNT_W = $clog2(SEQ_W + 1);

  logic [SEQ_W-1:0] dvd_r;
  logic [BS_W-1:0]  div_r;
  logic [BS_W-1:0]  rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [BS_W:0]    trial;
  logic [BS_W:0]    diff;

  // Shift in next dividend bit and try subtract
  always_comb begin
    trial = {rem_r, dvd_r[SEQ_W-1]};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      dvd_r  <= dividend;
      div_r  <= divisor;
      rem_r  <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[SEQ_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[BS_W-1:0];
      end else begin
        rem_r <= trial[BS_W-1:0];
      end
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SEQ_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign rem_nz = (rem_r != '0);

endmodule : pgmr_mod
`default_nettype wire

// File: src/parity_group_multicast_router.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parity_group_multicast_router
// Member table router: joins senders, checks sequence, fans out to the
// opposite parity group.
// ----------------------------------------------------------------------------
// One header is taken while busy is low. The remainder unit does the block
// size check while the member table is scanned one entry a cycle through its
// single read port; once both are done, the update step writes the table,
// the decide step reports or arms the fan-out, and a second pass over the
// table emits the forward transactions. Results appear on out_valid for
// exactly one cycle each and cannot be held off; out_last marks the final
// one of a header. The configuration channel is always ready; write it only
// while idle.
module parity_group_multicast_router
  import pgmr_pkg::*;
#(
  parameter int unsigned MAX_MEMBERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ID_W-1:0]   in_sender_id,
  input  wire logic [SEQ_W-1:0]  in_sequence_req,
  input  wire logic [IP_W-1:0]   in_source_ip,
  input  wire logic [PORT_W-1:0] in_source_port,
  output logic                   out_valid,
  output logic                   out_result_kind,
  output logic [IP_W-1:0]        out_dest_ip,
  output logic [PORT_W-1:0]      out_dest_port,
  output logic [ID_W-1:0]        out_echo_id,
  output logic [SEQ_W-1:0]       out_echo_sequence,
  output logic                   out_misaligned,
  output logic                   out_gap_seen,
  output logic [SEQ_W-1:0]       out_missing_sequence,
  output logic                   out_table_full,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [BS_W-1:0]   cfg_block_size
);

  localparam int unsigned AW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int unsigned CNT_W = AW + 1;
  localparam int unsigned GC_W  = $clog2(MAX_MEMBERS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_MEMBERS);

  pgmr_state_t state_r, state_nxt;

  logic [BS_W-1:0]        bs_r;
  logic [MAX_MEMBERS-1:0] slot_valid_r;
  logic [GC_W-1:0]        even_cnt_r, odd_cnt_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   rd_vld_r;
  logic [AW-1:0]          rd_idx_r;

  logic [ID_W-1:0]   id_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [IP_W-1:0]   ip_r;
  logic [PORT_W-1:0] port_r;
  logic [SEQ_W-1:0]  miss_r;
  logic              mis_r, gap_r, full_r;

  logic              found_r, free_vld_r;
  logic [AW-1:0]     found_idx_r, free_idx_r;
  pgmr_entry_t       found_ent_r;

  logic              pend_r;
  logic [IP_W-1:0]   pend_ip_r;
  logic [PORT_W-1:0] pend_port_r;

  logic              out_valid_r, out_kind_r, out_last_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;

  logic        accept, issue, cmp_hit, fan_hit, both_groups, parity;
  logic        mem_we, mod_done, mod_rem_nz;
  logic [AW-1:0] mem_waddr;
  pgmr_entry_t mem_wdata, mem_rdata;

  assign accept      = start && (state_r == ST_IDLE);
  assign parity      = id_r[0];
  assign both_groups = (even_cnt_r != '0) && (odd_cnt_r != '0);
  assign issue       = ((state_r == ST_SCAN) || (state_r == ST_FAN)) && (cnt_r < LAST_CNT);
  assign cmp_hit     = rd_vld_r && slot_valid_r[rd_idx_r] && (mem_rdata.id == id_r);
  assign fan_hit     = rd_vld_r && slot_valid_r[rd_idx_r] && (mem_rdata.id[0] != parity);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == LAST_CNT) state_nxt = ST_WAIT;
      ST_WAIT:   if (mod_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = both_groups ? ST_FAN : ST_IDLE;
      ST_FAN:    if (cnt_r == LAST_CNT) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Table write for the update step
  always_comb begin
    mem_we    = (state_r == ST_UPDATE) && (found_r || !parity || free_vld_r);
    mem_waddr = free_idx_r;
    mem_wdata = '{id: id_r, ip: ip_r, port: port_r, last_seq: seq_r};
    if (found_r) begin
      mem_waddr          = found_idx_r;
      mem_wdata          = found_ent_r;
      mem_wdata.last_seq = seq_r;
    end else if (!parity) begin
      mem_waddr = '0;
    end
  end

  pgmr_mem #(
    .DEPTH (MAX_MEMBERS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  pgmr_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_sequence_req),
    .divisor  (bs_r),
    .done     (mod_done),
    .rem_nz   (mod_rem_nz)
  );

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bs_r         <= BLOCK_SIZE_RESET;
      slot_valid_r <= '0;
      even_cnt_r   <= '0;
      odd_cnt_r    <= '0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      rd_vld_r    <= issue;
      rd_idx_r    <= cnt_r[AW-1:0];
      if (issue) cnt_r <= cnt_r + CNT_W'(1);

      if (cfg_valid) bs_r <= cfg_block_size;

      // Latch header, start scan
      if (accept) begin
        id_r       <= in_sender_id;
        seq_r      <= in_sequence_req;
        ip_r       <= in_source_ip;
        port_r     <= in_source_port;
        miss_r     <= in_sequence_req - {{(SEQ_W-BS_W){1'b0}}, bs_r};
        gap_r      <= 1'b0;
        full_r     <= 1'b0;
        found_r    <= 1'b0;
        free_vld_r <= 1'b0;
        cnt_r      <= '0;
      end

      // Look for the sender and the lowest free slot
      if (state_r == ST_SCAN && rd_vld_r) begin
        if (!found_r && cmp_hit) begin
          found_r     <= 1'b1;
          found_idx_r <= rd_idx_r;
          found_ent_r <= mem_rdata;
        end
        if (!free_vld_r && !slot_valid_r[rd_idx_r]) begin
          free_vld_r <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end

      // Take the alignment check
      if (state_r == ST_WAIT && mod_done) begin
        mis_r <= (bs_r == '0) ? (seq_r != '0) : mod_rem_nz;
      end

      // Update membership
      if (state_r == ST_UPDATE) begin
        if (found_r) begin
          gap_r <= (found_ent_r.last_seq != miss_r);
        end else if (!parity) begin
          slot_valid_r    <= '0;
          slot_valid_r[0] <= 1'b1;
          even_cnt_r      <= GC_W'(1);
          odd_cnt_r       <= '0;
        end else if (free_vld_r) begin
          slot_valid_r[free_idx_r] <= 1'b1;
          odd_cnt_r                <= odd_cnt_r + GC_W'(1);
        end else begin
          full_r <= 1'b1;
        end
      end

      // Report alone, or arm the fan-out pass
      if (state_r == ST_DECIDE) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
        if (!both_groups) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= RESULT_REPORT;
          out_ip_r    <= '0;
          out_port_r  <= '0;
          out_last_r  <= 1'b1;
        end
      end

      // Hold one forward back so the final one can be marked
      if (state_r == ST_FAN && fan_hit) begin
        if (pend_r) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= RESULT_FORWARD;
          out_ip_r    <= pend_ip_r;
          out_port_r  <= pend_port_r;
          out_last_r  <= 1'b0;
        end
        pend_r      <= 1'b1;
        pend_ip_r   <= mem_rdata.ip;
        pend_port_r <= mem_rdata.port;
      end

      // Drain the held forward as the final transaction
      if (state_r == ST_FLUSH) begin
        out_valid_r <= 1'b1;
        out_last_r  <= 1'b1;
        out_kind_r  <= pend_r ? RESULT_FORWARD : RESULT_REPORT;
        out_ip_r    <= pend_r ? pend_ip_r : '0;
        out_port_r  <= pend_r ? pend_port_r : '0;
        pend_r      <= 1'b0;
      end
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_kind_r;
  assign out_dest_ip          = out_ip_r;
  assign out_dest_port        = out_port_r;
  assign out_echo_id          = id_r;
  assign out_echo_sequence    = seq_r;
  assign out_misaligned       = mis_r;
  assign out_gap_seen         = gap_r;
  assign out_missing_sequence = miss_r;
  assign out_table_full       = full_r;
  assign out_last             = out_last_r;

endmodule : parity_group_multicast_router
`default_nettype wire

// File: src/pgmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgmr_checker
// Port level checks of the router, bound to the top level.
// ----------------------------------------------------------------------------
module pgmr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_result_kind,
  input wire logic [31:0] out_dest_ip,
  input wire logic [15:0] out_dest_port,
  input wire logic        out_last
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accept");

  // A report is always the single, final result
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_last) else $error("report not last");

  // A report carries no destination
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_dest_ip == '0 && out_dest_port == '0)
    else $error("report with destination");

  // The final result frees the block, earlier ones keep it busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy on final result");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("idle with results pending");

endmodule : pgmr_checker

bind parity_group_multicast_router pgmr_checker u_pgmr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_dest_ip     (out_dest_ip),
  .out_dest_port   (out_dest_port),
  .out_last        (out_last)
);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity group multicast router testbench
// Drives packet headers through the start/busy handshake, keeps its own
// member table to predict every forward and report transaction, and checks
// each transaction field by field as it leaves the router.
// ----------------------------------------------------------------------------
module testbench;
  import pgmr_pkg::*;

  localparam int unsigned MEMBERS = 16;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct {
    logic              kind;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic [ID_W-1:0]   echo_id;
    logic [SEQ_W-1:0]  echo_seq;
    logic              misaligned;
    logic              gap_seen;
    logic [SEQ_W-1:0]  missing_seq;
    logic              table_full;
    logic              last;
  } route_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [ID_W-1:0]   in_sender_id;
  logic [SEQ_W-1:0]  in_sequence_req;
  logic [IP_W-1:0]   in_source_ip;
  logic [PORT_W-1:0] in_source_port;
  logic              out_valid;
  logic              out_result_kind;
  logic [IP_W-1:0]   out_dest_ip;
  logic [PORT_W-1:0] out_dest_port;
  logic [ID_W-1:0]   out_echo_id;
  logic [SEQ_W-1:0]  out_echo_sequence;
  logic              out_misaligned;
  logic              out_gap_seen;
  logic [SEQ_W-1:0]  out_missing_sequence;
  logic              out_table_full;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BS_W-1:0]   cfg_block_size;

  // Predicted member table and configuration
  logic [BS_W-1:0]   stride;
  logic              member_valid [MEMBERS];
  logic [ID_W-1:0]   member_id    [MEMBERS];
  logic [IP_W-1:0]   member_ip    [MEMBERS];
  logic [PORT_W-1:0] member_port  [MEMBERS];
  logic [SEQ_W-1:0]  member_seq   [MEMBERS];
  int unsigned       even_members;
  int unsigned       odd_members;

  route_result_t pending_routes[$];
  int errors;
  int headers_sent;
  int routes_seen;
  int forwards_seen;
  int full_seen;
  int burst_left;

  parity_group_multicast_router #(.MAX_MEMBERS(MEMBERS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sender_id(in_sender_id), .in_sequence_req(in_sequence_req),
    .in_source_ip(in_source_ip), .in_source_port(in_source_port),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_dest_ip(out_dest_ip), .out_dest_port(out_dest_port),
    .out_echo_id(out_echo_id), .out_echo_sequence(out_echo_sequence),
    .out_misaligned(out_misaligned), .out_gap_seen(out_gap_seen),
    .out_missing_sequence(out_missing_sequence), .out_table_full(out_table_full),
    .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_block_size(cfg_block_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic forget_members();
    for (int i = 0; i < MEMBERS; i++) member_valid[i] = 1'b0;
    even_members = 0;
    odd_members = 0;
  endtask

  // Update the member table and queue the transactions one header causes
  task automatic predict_routes(input logic [ID_W-1:0] id, input logic [SEQ_W-1:0] seq,
                                input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
    route_result_t r;
    int hit;
    int free_slot;
    int n;
    hit = -1;
    free_slot = -1;
    n = 0;
    r.echo_id = id;
    r.echo_seq = seq;
    r.misaligned = (stride == 0) ? (seq != 0) : ((seq % stride) != 0);
    r.missing_seq = seq - SEQ_W'(stride);
    r.gap_seen = 1'b0;
    r.table_full = 1'b0;
    r.last = 1'b0;
    for (int i = 0; i < MEMBERS; i++)
      if (hit < 0 && member_valid[i] && member_id[i] == id) hit = i;
    if (hit >= 0) begin
      r.gap_seen = (member_seq[hit] != r.missing_seq);
      member_seq[hit] = seq;
    end else begin
      if (!id[0]) forget_members();
      for (int i = 0; i < MEMBERS; i++)
        if (free_slot < 0 && !member_valid[i]) free_slot = i;
      if (free_slot < 0) begin
        r.table_full = 1'b1;
      end else begin
        member_valid[free_slot] = 1'b1;
        member_id[free_slot] = id;
        member_ip[free_slot] = ip;
        member_port[free_slot] = port;
        member_seq[free_slot] = seq;
        if (id[0]) odd_members++;
        else even_members++;
      end
    end
    // Fan out to the opposite group in slot order
    if (even_members != 0 && odd_members != 0) begin
      for (int i = 0; i < MEMBERS; i++) begin
        if (member_valid[i] && member_id[i][0] != id[0]) begin
          r.kind = RESULT_FORWARD;
          r.dest_ip = member_ip[i];
          r.dest_port = member_port[i];
          pending_routes.push_back(r);
          n++;
        end
      end
    end
    if (n == 0) begin
      r.kind = RESULT_REPORT;
      r.dest_ip = '0;
      r.dest_port = '0;
      pending_routes.push_back(r);
    end
    r = pending_routes[$];
    r.last = 1'b1;
    pending_routes[$] = r;
  endtask

  // Send one header and hold off between bursts
  task automatic send_header(input logic [ID_W-1:0] id, input logic [SEQ_W-1:0] seq,
                             input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_sender_id = id;
    in_sequence_req = seq;
    in_source_ip = ip;
    in_source_port = port;
    do @(posedge clk); while (busy);
    predict_routes(id, seq, ip, port);
    headers_sent++;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(40, 1);
    end
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Wait until every predicted transaction has left and the router is idle
  task automatic drain_routes();
    @(negedge clk);
    start = 1'b0;
    while (pending_routes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_stride(input logic [BS_W-1:0] value);
    drain_routes();
    cfg_valid = 1'b1;
    cfg_block_size = value;
    do @(posedge clk); while (!cfg_ready);
    stride = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Check each transaction against the oldest prediction
  always @(posedge clk) begin
    route_result_t w;
    if (rst_n && out_valid) begin
      routes_seen++;
      if (pending_routes.size() == 0) begin
        report_mismatch("unexpected transaction from id", 64'(out_echo_id), 64'd0);
      end else begin
        w = pending_routes.pop_front();
        if (out_result_kind == RESULT_FORWARD) forwards_seen++;
        if (out_table_full) full_seen++;
        if (out_result_kind !== w.kind) report_mismatch("result_kind", out_result_kind, w.kind);
        if (out_dest_ip !== w.dest_ip) report_mismatch("dest_ip", out_dest_ip, w.dest_ip);
        if (out_dest_port !== w.dest_port)
          report_mismatch("dest_port", out_dest_port, w.dest_port);
        if (out_echo_id !== w.echo_id) report_mismatch("echo_id", out_echo_id, w.echo_id);
        if (out_echo_sequence !== w.echo_seq)
          report_mismatch("echo_sequence", out_echo_sequence, w.echo_seq);
        if (out_misaligned !== w.misaligned)
          report_mismatch("misaligned", out_misaligned, w.misaligned);
        if (out_gap_seen !== w.gap_seen) report_mismatch("gap_seen", out_gap_seen, w.gap_seen);
        if (out_missing_sequence !== w.missing_seq)
          report_mismatch("missing_sequence", out_missing_sequence, w.missing_seq);
        if (out_table_full !== w.table_full)
          report_mismatch("table_full", out_table_full, w.table_full);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // Lone odd and even senders report, then pair up and forward
  task automatic test_join_and_report();
    send_header(32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    send_header(32'h0000_0001, 32'h1, 32'h0, 16'h0);
    send_header(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0A00_0001, 16'h0000);
    send_header(32'h0000_0003, 32'h7, 32'h0A00_0003, 16'h1234);
    send_header(32'hFFFF_FFFE, 32'h0, 32'h0, 16'h0);
    send_header(32'h0000_0001, 32'h5, 32'h1, 16'h1);
    // A new even sender wipes the table
    send_header(32'h0000_0000, 32'h10, 32'h0B00_0000, 16'h8000);
    drain_routes();
  endtask

  // Fill every slot, then offer one more odd sender
  task automatic test_table_full();
    send_header(32'h0000_0002, 32'h0, 32'hC0A8_0002, 16'd2000);
    for (int i = 0; i < MEMBERS - 1; i++)
      send_header(32'(32'h100 + 2 * i + 1), 32'(i), 32'(32'hC0A8_0100 + i),
                  16'(3000 + i));
    send_header(32'h0000_0FFF, 32'h40, 32'hDEAD_BEEF, 16'hBEEF);
    send_header(32'h0000_0002, 32'h1, 32'h0, 16'h0);
    drain_routes();
  endtask

  // Stride of zero and of the largest value
  task automatic test_stride_extremes();
    write_stride(16'd0);
    send_header(32'h0000_0004, 32'h0, 32'h1, 16'd1);
    send_header(32'h0000_0004, 32'h9, 32'h1, 16'd1);
    write_stride(16'hFFFF);
    send_header(32'h0000_0005, 32'hFFFF, 32'h2, 16'd2);
    send_header(32'h0000_0005, 32'h1FFFE, 32'h2, 16'd2);
    send_header(32'h0000_0004, 32'h3, 32'h1, 16'd1);
    drain_routes();
  endtask

  // Mostly well-formed streams from known members, with some noise
  task automatic test_random_traffic(input int count);
    logic [ID_W-1:0] id;
    logic [SEQ_W-1:0] seq;
    int pick;
    int slot;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      slot = $urandom_range(MEMBERS - 1);
      if (pick < 65 && member_valid[slot]) begin
        id = member_id[slot];
        seq = member_seq[slot] + SEQ_W'(stride);
        if ($urandom_range(9) == 0) seq = $urandom;
      end else if (pick < 92) begin
        id = {31'($urandom_range(7) == 0 ? $urandom : $urandom_range(40)), 1'b1};
        id[ID_W-1] = 1'($urandom_range(1));
        seq = $urandom_range(3) == 0 ? $urandom : 32'(stride * $urandom_range(50));
      end else begin
        id = {31'($urandom), 1'b0};
        seq = $urandom;
      end
      send_header(id, seq, $urandom, 16'($urandom));
    end
    drain_routes();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_sender_id = '0;
    in_sequence_req = '0;
    in_source_ip = '0;
    in_source_port = '0;
    cfg_valid = 1'b0;
    cfg_block_size = '0;
    errors = 0;
    headers_sent = 0;
    routes_seen = 0;
    forwards_seen = 0;
    full_seen = 0;
    burst_left = 0;
    stride = BLOCK_SIZE_RESET;
    forget_members();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_join_and_report();
    test_table_full();
    test_stride_extremes();
    write_stride(16'd1);
    test_random_traffic(90);
    write_stride(16'd4);
    test_random_traffic(90);
    write_stride(16'($urandom_range(65535, 2)));
    test_random_traffic(60);

    $display("covered %0d headers, %0d transactions (%0d forwards, %0d table full)",
             headers_sent, routes_seen, forwards_seen, full_seen);
    $display("strides 0, 1, 4, 65535 and one random value");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("timeout with %0d transactions outstanding", pending_routes.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: parity_group_multicast_router.f
src/pgmr_pkg.sv
src/pgmr_mem.sv
src/pgmr_mod.sv
src/parity_group_multicast_router.sv
src/pgmr_checker.sv
dv/testbench.sv
